/* hdl/rtt_pkg.sv */
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants of the range translation table
// Holds the request and response words, the table entry layout, the action
// and status codes, and the control and result bundles of the scan unit.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned AddrW       = 64;
  localparam logic [AddrW-1:0] AnySize = AddrW'(1);

  typedef enum logic [1:0] {
    ACT_ADD       = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_TRANSLATE = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NOT_FOUND      = 3'd1,
    ST_TAG_INTERNAL   = 3'd2,
    ST_RANGE_OVERFLOW = 3'd3,
    ST_MISMATCH       = 3'd4,
    ST_NOT_BASE       = 3'd5,
    ST_FULL           = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_DECIDE,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e          action;
    logic [AddrW-1:0] handle;
    logic [AddrW-1:0] mapped_address;
    logic [AddrW-1:0] length;
    logic             mapping_type;
  } req_t;

  typedef struct packed {
    logic             ok;
    status_e          status;
    logic [AddrW-1:0] translated_address;
    logic [AddrW-1:0] remaining_length;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic             is_tag;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
    logic [AddrW-1:0] target;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic start;
    logic vld;
  } scan_ctl_t;

  typedef struct packed {
    logic             exact;
    logic             pred;
    logic             free_found;
    logic             is_tag;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
    logic [AddrW-1:0] target;
  } scan_res_t;

endpackage

/* hdl/rtt_ram.sv */
// ----------------------------------------------------------------------------
// rtt_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rtt_scan.sv */
// ----------------------------------------------------------------------------
// rtt_scan: entry compare unit of the translation table
// Looks at one table entry per cycle and keeps the exact base hit, or else
// the valid entry with the largest base below the handle, and the first
// free slot.
// ----------------------------------------------------------------------------
module rtt_scan #(
  parameter int unsigned IW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rtt_pkg::scan_ctl_t     ctl_i,
  input  logic [IW-1:0]          idx_i,
  input  rtt_pkg::entry_t        entry_i,
  input  logic [rtt_pkg::AddrW-1:0] handle_i,
  output rtt_pkg::scan_res_t     res_o,
  output logic [IW-1:0]          sel_idx_o,
  output logic [IW-1:0]          free_idx_o
);
  import rtt_pkg::*;

  logic             exact_q, exact_d;
  logic             pred_q, pred_d;
  logic             free_q, free_d;
  logic             tag_q, tag_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] len_q, len_d;
  logic [AddrW-1:0] target_q, target_d;
  logic [IW-1:0]    sel_idx_q, sel_idx_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic             is_eq, is_below, beats_pred, take;

  always_comb begin
    is_eq      = entry_i.base == handle_i;
    is_below   = entry_i.base < handle_i;
    beats_pred = !pred_q || (entry_i.base > base_q);
    take       = 1'b0;
    exact_d    = exact_q;
    pred_d     = pred_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (ctl_i.start) begin
      exact_d = 1'b0;
      pred_d  = 1'b0;
      free_d  = 1'b0;
    end else if (ctl_i.vld) begin
      if (entry_i.valid) begin
        if (!exact_q && is_eq) begin
          take    = 1'b1;
          exact_d = 1'b1;
        end else if (!exact_q && is_below && beats_pred) begin
          take   = 1'b1;
          pred_d = 1'b1;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = idx_i;
      end
    end
    tag_d     = take ? entry_i.is_tag : tag_q;
    base_d    = take ? entry_i.base : base_q;
    len_d     = take ? entry_i.len : len_q;
    target_d  = take ? entry_i.target : target_q;
    sel_idx_d = take ? idx_i : sel_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_q <= 1'b0;
      pred_q  <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      exact_q <= exact_d;
      pred_q  <= pred_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q      <= tag_d;
    base_q     <= base_d;
    len_q      <= len_d;
    target_q   <= target_d;
    sel_idx_q  <= sel_idx_d;
    free_idx_q <= free_idx_d;
  end

  always_comb begin
    res_o.exact      = exact_q;
    res_o.pred       = pred_q;
    res_o.free_found = free_q;
    res_o.is_tag     = tag_q;
    res_o.base       = base_q;
    res_o.len        = len_q;
    res_o.target     = target_q;
  end

  assign sel_idx_o  = sel_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

/* hdl/range_translation_table.sv */
// ----------------------------------------------------------------------------
// range_translation_table: range and tag address translation table
// Sequence: add, remove and translate scan the table RAM one entry per cycle,
// then pass the drain, calc and decide states; clear walks the table. A new
// request is accepted only in the idle state, after the last result is loaded.
// Reset: a sweep clears the valid bits in the RAM; no request is accepted
// until it finishes.
// ----------------------------------------------------------------------------
module range_translation_table #(
  parameter int unsigned ENTRIES = rtt_pkg::ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rtt_pkg::req_t req_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output rtt_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i
);
  import rtt_pkg::*;

  // Index width; a one-entry table still gets a one-bit address.
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  // Sequencer state and the captured request word.
  state_e        state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  req_t          req_q;
  logic          accept;

  // The read data of the RAM belongs to the address issued in the cycle
  // before; these registers follow it.
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  // RAM ports.
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [EntryW-1:0] rdata;
  entry_t        rentry;

  // Scan unit results.
  scan_ctl_t     scan_ctl;
  scan_res_t     scan_res;
  logic [IW-1:0] sel_idx, free_idx;

  // Arithmetic stage between the scan and the decision: the last handle of
  // the candidate entry, the last handle of the request and the offset.
  logic [AddrW-1:0] last_q, req_last_q, off_q, size;

  // Result of the current request and the output register.
  rsp_t res_q, res_d;
  rsp_t rsp_q;
  logic rsp_valid_q;
  logic rsp_load;

  status_e lk_status;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // --------------------------------------------------------------------------
  // Table storage: one RAM word per entry, valid bit included.
  // --------------------------------------------------------------------------
  rtt_ram #(
    .WIDTH (EntryW),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  assign rentry = entry_t'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
  end

  // --------------------------------------------------------------------------
  // Scan unit: one compare per cycle over the entries read from the RAM.
  // --------------------------------------------------------------------------
  assign scan_ctl.start = accept;
  assign scan_ctl.vld   = rd_vld_q;

  rtt_scan #(
    .IW (IW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (rd_idx_q),
    .entry_i    (rentry),
    .handle_i   (req_q.handle),
    .res_o      (scan_res),
    .sel_idx_o  (sel_idx),
    .free_idx_o (free_idx)
  );

  // --------------------------------------------------------------------------
  // Arithmetic stage. Add checks the whole requested range; remove and
  // translate check a single byte. All sums wrap at 64 bits.
  // --------------------------------------------------------------------------
  assign size = (req_q.action == ACT_ADD) ? req_q.length : AnySize;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      last_q     <= scan_res.base + scan_res.len - AddrW'(1);
      req_last_q <= req_q.handle + size - AddrW'(1);
      off_q      <= req_q.handle - scan_res.base;
    end
  end

  // Lookup outcome. An exact base hit succeeds without any range checks.
  // For a predecessor, the handle lies above its base by construction, so
  // only the upper end needs a test.
  always_comb begin
    if (scan_res.exact) begin
      lk_status = ST_OK;
    end else if (!scan_res.pred) begin
      lk_status = ST_NOT_FOUND;
    end else if (req_q.handle > last_q) begin
      lk_status = ST_NOT_FOUND;
    end else if (scan_res.is_tag) begin
      lk_status = ST_TAG_INTERNAL;
    end else if (req_last_q > last_q) begin
      lk_status = ST_RANGE_OVERFLOW;
    end else begin
      lk_status = ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state, RAM writes and the result word.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    we       = 1'b0;
    waddr    = cnt_q;
    wdata    = '0;
    res_d    = res_q;
    rsp_load = 1'b0;

    case (state_q)
      S_INIT: begin
        // Power-up sweep: every RAM word gets a cleared valid bit.
        we    = 1'b1;
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = (req_i.action == ACT_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last entry read is compared in this cycle.
        state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_d = '0;
        res_d.status = lk_status;
        case (req_q.action)
          ACT_ADD: begin
            if (lk_status == ST_OK) begin
              // Only an exact duplicate of a stored entry is accepted.
              if (!(scan_res.exact && scan_res.target == req_q.mapped_address &&
                    scan_res.len == req_q.length &&
                    scan_res.is_tag == req_q.mapping_type)) begin
                res_d.status = ST_MISMATCH;
              end
            end else if (lk_status == ST_NOT_FOUND) begin
              if (scan_res.free_found) begin
                we           = 1'b1;
                waddr        = free_idx;
                wdata.valid  = 1'b1;
                wdata.is_tag = req_q.mapping_type;
                wdata.base   = req_q.handle;
                wdata.len    = req_q.length;
                wdata.target = req_q.mapped_address;
                res_d.status = ST_OK;
              end else begin
                res_d.status = ST_FULL;
              end
            end
          end
          ACT_REMOVE: begin
            if (lk_status == ST_OK) begin
              if (scan_res.exact) begin
                we    = 1'b1;
                waddr = sel_idx;
              end else begin
                res_d.status = ST_NOT_BASE;
              end
            end
          end
          ACT_TRANSLATE: begin
            if (lk_status == ST_OK) begin
              res_d.translated_address = scan_res.target + off_q;
              res_d.remaining_length   = scan_res.len - off_q;
            end
          end
          default: begin
            res_d.status = ST_OK;
          end
        endcase
        res_d.ok = (res_d.status == ST_OK);
        state_d  = S_DONE;
      end
      S_CLEAR: begin
        // Clear walks the table and drops every valid bit.
        we    = 1'b1;
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d    = '0;
          res_d    = '0;
          res_d.ok = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (rsp_load) begin
      rsp_q <= res_q;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule
